// ===== src/brf_pkg.sv =====
// shared types and constants of the byte ring fifo
`timescale 1ns / 1ps

package brf_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int MAX_RUN     = 64;

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int LEN_W = 9;
    localparam int RUN_W = 7;
    localparam int CNT_W = $clog2(MAX_RUN + 1);
    // common width for pointer, length and occupancy arithmetic
    localparam int CALC_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);

    localparam logic [1:0] FN_PUSH = 2'd0;
    localparam logic [1:0] FN_POP  = 2'd1;
    localparam logic [1:0] FN_PEEK = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [7:0]       data_in;
        logic [RUN_W-1:0] run_length;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] data_out;
        logic [7:0] free_space;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } t_mem_req;

    // result fields known at issue, byte comes from the store's registered read port
    typedef struct packed {
        logic       ok;
        logic       use_data;
        logic [7:0] free_space;
        logic       last;
    } t_res_meta;

endpackage

// ===== src/brf_store.sv =====
// byte store of the ring fifo, one write and one registered read port
`timescale 1ns / 1ps

module brf_store import brf_pkg::*; (
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/brf_ctrl.sv =====
// pointer state, length register, peek sequencer and issue stage
`timescale 1ns / 1ps

module brf_ctrl import brf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             i_out_free,
    output t_mem_req         o_mem_req,
    output logic             o_s1_valid,
    output t_res_meta        o_s1
);

    logic [LEN_W-1:0]  r_len, n_len;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic              r_peek_busy, n_peek_busy;
    logic [PTR_W-1:0]  r_peek_rp, n_peek_rp;
    logic [CNT_W-1:0]  r_peek_left, n_peek_left;
    logic              r_s1_valid, n_s1_valid;
    t_res_meta         r_s1, n_s1;

    logic [LEN_W-1:0]  act_len;
    logic [CALC_W-1:0] len_w;
    logic [CALC_W-1:0] occ;
    logic [CNT_W-1:0]  run_c;
    logic [CNT_W-1:0]  count;
    logic              issue_ok;
    logic              in_accept;
    logic              peek_step;
    t_mem_req          mem_req;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                  input logic [CALC_W-1:0] len);
        logic [CALC_W-1:0] s;
        s = CALC_W'(p) + CALC_W'(1);
        return (s == len) ? '0 : s[PTR_W-1:0];
    endfunction

    function automatic logic [7:0] free_of(input logic [CALC_W-1:0] len,
                                           input logic [CALC_W-1:0] occ_after);
        logic [CALC_W-1:0] f;
        f = len - CALC_W'(1) - occ_after;
        return (f > CALC_W'(255)) ? 8'd255 : f[7:0];
    endfunction

    // clamp the length register into the usable range
    always_comb begin
        if (r_len < LEN_MIN) begin
            act_len = LEN_MIN;
        end else if (32'(r_len) > STORE_DEPTH) begin
            act_len = LEN_W'(STORE_DEPTH);
        end else begin
            act_len = r_len;
        end
    end

    assign len_w = CALC_W'(act_len);
    assign occ   = (r_wp >= r_rp) ? CALC_W'(r_wp) - CALC_W'(r_rp)
                                  : CALC_W'(r_wp) + len_w - CALC_W'(r_rp);

    always_comb begin
        if (i_in_item.run_length == '0) begin
            run_c = CNT_W'(1);
        end else if (i_in_item.run_length > RUN_W'(MAX_RUN)) begin
            run_c = CNT_W'(MAX_RUN);
        end else begin
            run_c = CNT_W'(i_in_item.run_length);
        end
    end

    assign count = (occ < CALC_W'(run_c)) ? CNT_W'(occ) : run_c;

    assign issue_ok   = !r_s1_valid || i_out_free;
    assign o_in_stall = r_peek_busy || !issue_ok;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign peek_step  = r_peek_busy && issue_ok;

    always_comb begin
        n_len       = r_len;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_peek_busy = r_peek_busy;
        n_peek_rp   = r_peek_rp;
        n_peek_left = r_peek_left;
        n_s1_valid  = r_s1_valid;
        n_s1        = r_s1;
        mem_req     = '0;

        if (in_accept) begin
            n_s1_valid         = 1'b1;
            n_s1.ok            = 1'b0;
            n_s1.use_data      = 1'b0;
            n_s1.last          = 1'b1;
            n_s1.free_space    = free_of(len_w, occ);
            unique case (i_in_item.func)
                FN_PUSH: begin
                    if (ptr_next(r_wp, len_w) != r_rp) begin
                        mem_req.we      = 1'b1;
                        mem_req.waddr   = r_wp;
                        mem_req.wdata   = i_in_item.data_in;
                        n_wp            = ptr_next(r_wp, len_w);
                        n_s1.ok         = 1'b1;
                        n_s1.free_space = free_of(len_w, occ + CALC_W'(1));
                    end
                end
                FN_POP: begin
                    if (occ != '0) begin
                        mem_req.re      = 1'b1;
                        mem_req.raddr   = r_rp;
                        n_rp            = ptr_next(r_rp, len_w);
                        n_s1.ok         = 1'b1;
                        n_s1.use_data   = 1'b1;
                        n_s1.free_space = free_of(len_w, occ - CALC_W'(1));
                    end
                end
                FN_PEEK: begin
                    if (occ != '0) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_rp;
                        n_s1.ok       = 1'b1;
                        n_s1.use_data = 1'b1;
                        n_s1.last     = (count == CNT_W'(1));
                        if (count != CNT_W'(1)) begin
                            n_peek_busy = 1'b1;
                            n_peek_rp   = ptr_next(r_rp, len_w);
                            n_peek_left = count - CNT_W'(1);
                        end
                    end
                end
                default: begin
                    n_s1.ok = 1'b0;
                end
            endcase
        end else if (peek_step) begin
            mem_req.re      = 1'b1;
            mem_req.raddr   = r_peek_rp;
            n_s1_valid      = 1'b1;
            n_s1.ok         = 1'b1;
            n_s1.use_data   = 1'b1;
            n_s1.free_space = free_of(len_w, occ);
            n_s1.last       = (r_peek_left == CNT_W'(1));
            n_peek_rp       = ptr_next(r_peek_rp, len_w);
            n_peek_left     = r_peek_left - CNT_W'(1);
            if (r_peek_left == CNT_W'(1)) begin
                n_peek_busy = 1'b0;
            end
        end else if (i_out_free) begin
            n_s1_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_len = i_cfg_data;
            n_wp  = '0;
            n_rp  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_wp        <= '0;
            r_rp        <= '0;
            r_peek_busy <= 1'b0;
            r_peek_left <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_peek_busy <= n_peek_busy;
            r_peek_left <= n_peek_left;
            r_s1_valid  <= n_s1_valid;
        end
        r_peek_rp <= n_peek_rp;
        r_s1      <= n_s1;
    end

    assign o_mem_req  = mem_req;
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

// ===== src/byte_ring_fifo.sv =====
// top level of the byte ring fifo: control, byte store and output register
`timescale 1ns / 1ps

// byte ring fifo with a programmable ring length (2 to 256 slots, one slot
// always kept empty). a push or pop transaction is taken every cycle while the
// input is not stalled; the path is issue (pointers update and the store is
// read or written), store read, then the output register. a peek run returns
// one byte per cycle while the output is free, min(run, occupancy) bytes in
// all with run being run_length held to 1 .. 64, or a single failed result on
// an empty fifo, and input transactions are held off until its last byte has
// issued, since the single store read port serves one byte a cycle. writing
// the length register empties the fifo; write it only while no transaction is in flight.

module byte_ring_fifo import brf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    // length register write
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data
);

    t_mem_req   mem_req;
    logic [7:0] rd_data;
    logic       s1_valid;
    t_res_meta  s1;
    logic       out_free;

    logic       r_out_valid;
    t_out_item  r_out_item;

    // output register is free when empty or its transaction completes now
    assign out_free = !r_out_valid || !i_out_stall;

    brf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_out_free (out_free),
        .o_mem_req  (mem_req),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    // read data stays put while the issue stage holds, no new read is issued
    brf_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // output register: merges the stored byte with the issue-time fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_valid;
        end
        if (out_free && s1_valid) begin
            r_out_item.ok         <= s1.ok;
            r_out_item.data_out   <= s1.use_data ? rd_data : 8'd0;
            r_out_item.free_space <= s1.free_space;
            r_out_item.last       <= s1.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== tb/brf_checker.sv =====
// checker for the byte ring fifo: predicts results and compares them
`timescale 1ns / 1ps

module brf_checker import brf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    logic [7:0]       ring_store [STORE_DEPTH];
    int               wr_idx = 0;
    int               rd_idx = 0;
    logic [LEN_W-1:0] ring_length = LEN_RESET;
    t_out_item        owed_results [$];
    int               fails = 0;
    int               checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;
    assign o_pending    = owed_results.size();

    // slots in the ring, the register value clamped to 2 .. STORE_DEPTH
    function automatic int ring_span();
        int span;
        span = int'(ring_length);
        if (span < 2) span = 2;
        if (span > STORE_DEPTH) span = STORE_DEPTH;
        return span;
    endfunction

    function automatic int fill_level(int span);
        return (wr_idx + span - rd_idx) % span;
    endfunction

    function automatic logic [7:0] room_left();
        int span;
        int room;
        span = ring_span();
        room = span - fill_level(span) - 1;
        return (room > 255) ? 8'd255 : 8'(room);
    endfunction

    task automatic owe(input logic ok, input logic [7:0] data, input logic last);
        t_out_item res;
        res.ok         = ok;
        res.data_out   = data;
        res.free_space = room_left();
        res.last       = last;
        owed_results.push_back(res);
    endtask

    task automatic apply_fifo_op(input t_in_item it);
        int span;
        int nxt;
        int occ;
        int run;
        int count;
        int rp;
        int i;
        logic [7:0] b;
        span = ring_span();
        case (it.func)
            FN_PUSH: begin
                nxt = (wr_idx + 1) % span;
                if (nxt != rd_idx) begin
                    ring_store[wr_idx] = it.data_in;
                    wr_idx = nxt;
                    owe(1'b1, 8'd0, 1'b1);
                end else begin
                    owe(1'b0, 8'd0, 1'b1);
                end
            end
            FN_POP: begin
                if (wr_idx != rd_idx) begin
                    b = ring_store[rd_idx];
                    rd_idx = (rd_idx + 1) % span;
                    owe(1'b1, b, 1'b1);
                end else begin
                    owe(1'b0, 8'd0, 1'b1);
                end
            end
            FN_PEEK: begin
                run = int'(it.run_length);
                if (run < 1) run = 1;
                if (run > MAX_RUN) run = MAX_RUN;
                occ = fill_level(span);
                if (occ == 0) begin
                    owe(1'b0, 8'd0, 1'b1);
                end else begin
                    count = (occ < run) ? occ : run;
                    rp = rd_idx;
                    for (i = 0; i < count; i++) begin
                        owe(1'b1, ring_store[rp], i == count - 1);
                        rp = (rp + 1) % span;
                    end
                end
            end
            default: begin
                owe(1'b0, 8'd0, 1'b1);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            wr_idx      = 0;
            rd_idx      = 0;
            ring_length = LEN_RESET;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with nothing expected: %p", i_out_item);
                    fails++;
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (i_out_item.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, i_out_item.ok);
                        fails++;
                    end
                    if (i_out_item.data_out !== want.data_out) begin
                        $error("data_out: expected %0d, got %0d",
                               want.data_out, i_out_item.data_out);
                        fails++;
                    end
                    if (i_out_item.free_space !== want.free_space) begin
                        $error("free_space: expected %0d, got %0d",
                               want.free_space, i_out_item.free_space);
                        fails++;
                    end
                    if (i_out_item.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_out_item.last);
                        fails++;
                    end
                end
            end
            // a length write empties the ring
            if (i_cfg_we) begin
                ring_length = i_cfg_data;
                wr_idx      = 0;
                rd_idx      = 0;
            end
            if (i_in_valid && !i_in_stall) apply_fifo_op(i_in_item);
        end
    end

endmodule

// ===== tb/tb_byte_ring_fifo.sv =====
// testbench top for the byte ring fifo: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_byte_ring_fifo;
    import brf_pkg::*;

    // selector value the block does not use
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam int HOLD_CYCLES  = 200;   // long output hold to back the block up
    localparam int STUCK_LIMIT  = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 10;    // quiet time after the last result
    localparam int PHASE_ITEMS  = 24;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_item   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_data  = '0;

    logic             in_stall;
    logic             out_valid;
    t_out_item        out_item;

    int fail_count;
    int pending;
    int checked;

    bit idle_on       = 1'b1;  // random idling on both sides
    bit hold_req      = 1'b0;  // asks the receiver for one long hold
    int items_sent    = 0;
    int lengths_used  = 0;

    // 2 ns clock, 1 ns high and 1 ns low
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    byte_ring_fifo DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    brf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // receiver: random stall, or one long hold when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_stall = idle_on && ($urandom_range(0, 99) < 10);
            end
        end
    end

    // watchdog: only counts while something is offered or owed
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else if (in_valid || pending != 0)
                stuck++;
        end
        $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // offer one input transaction, return at the falling edge after it is taken
    task automatic send(input logic [1:0] fn, input logic [7:0] b,
                        input logic [RUN_W-1:0] run);
        t_in_item it;
        it.func       = fn;
        it.data_in    = b;
        it.run_length = run;
        // sender gaps, valid low for a cycle at a time
        while (idle_on && $urandom_range(0, 99) < 10) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        // payload holds while stalled
        do @(posedge clk); while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result is back
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // length write only on an idle block; it clears both pointers
    task automatic set_length(input logic [LEN_W-1:0] len);
        settle();
        cfg_data = len;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
        lengths_used++;
    endtask

    // one random transaction, push share given in percent
    task automatic random_op(input int push_pct);
        logic [1:0]       fn;
        logic [RUN_W-1:0] run;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            fn = FN_PUSH;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      fn = FN_POP;
            else if (pick < 94) fn = FN_PEEK;
            else                fn = FN_UNUSED;
        end
        // mostly short peek runs, now and then any 7-bit value
        if ($urandom_range(0, 9) == 0) run = RUN_W'($urandom_range(0, 127));
        else if ($urandom_range(0, 9) == 0) run = RUN_W'(MAX_RUN);
        else run = RUN_W'($urandom_range(1, 16));
        send(fn, 8'($urandom_range(0, 255)), run);
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] phase_len [10];
        int p;
        int n;
        phase_len = '{9'd256, 9'd3, 9'd16, 9'd1, 9'd300, 9'd7, 9'd0, 9'd511, 9'd64, 9'd2};

        // synchronous reset
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty cases and the unused selector at the reset length
        send(FN_POP, 8'h00, 7'd1);
        send(FN_PEEK, 8'h00, 7'd0);
        send(FN_UNUSED, 8'hFF, 7'h7F);
        // byte extremes, then peeks with a zero run and an over-long run
        send(FN_PUSH, 8'h00, 7'd1);
        send(FN_PUSH, 8'hFF, 7'd1);
        send(FN_PUSH, 8'hA5, 7'd1);
        send(FN_PEEK, 8'h00, 7'd0);
        send(FN_PEEK, 8'h00, 7'h7F);
        send(FN_PEEK, 8'h00, 7'd2);
        repeat (4) send(FN_POP, 8'h00, 7'd1);

        // smallest ring: one byte fills it
        set_length(9'd2);
        send(FN_PUSH, 8'h11, 7'd1);
        send(FN_PUSH, 8'h22, 7'd1);
        send(FN_POP, 8'h00, 7'd1);

        // length below the minimum acts as 2
        set_length(9'd0);
        send(FN_PUSH, 8'h5A, 7'd1);
        send(FN_PUSH, 8'hC3, 7'd1);

        // ring of 5: fill, full push, then wrap the pointers and peek across
        set_length(9'd5);
        for (n = 0; n < 4; n++) send(FN_PUSH, 8'(n + 1), 7'd1);
        send(FN_PUSH, 8'h77, 7'd1);
        send(FN_POP, 8'h00, 7'd1);
        send(FN_POP, 8'h00, 7'd1);
        send(FN_PUSH, 8'h81, 7'd1);
        send(FN_PUSH, 8'h82, 7'd1);
        send(FN_PEEK, 8'h00, 7'h7F);

        // random phases over several ring lengths; push-heavy first to build depth
        for (p = 0; p < 10; p++) begin
            set_length(p == 6 ? LEN_W'($urandom_range(2, 256)) : phase_len[p]);
            // one phase with no idling at all
            idle_on = (p != 4);
            for (n = 0; n < PHASE_ITEMS; n++)
                random_op(n < PHASE_ITEMS / 2 ? 70 : 35);
        end
        idle_on = 1'b1;

        // backpressure: receiver holds off while pushes and long peeks keep coming
        set_length(9'd16);
        hold_req = 1'b1;
        for (n = 0; n < 30; n++) send(FN_PUSH, 8'($urandom_range(0, 255)), 7'd1);
        repeat (4) send(FN_PEEK, 8'h00, 7'd64);

        // drain, then a short quiet window for stray results
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run: %0d input transactions, %0d results compared, %0d length writes",
                 items_sent, checked, lengths_used);
        $display("run: push/pop/peek/unused ops, full and empty rings, wrap, long hold");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
src/brf_pkg.sv
src/brf_store.sv
src/brf_ctrl.sv
src/byte_ring_fifo.sv
tb/brf_checker.sv
tb/tb_byte_ring_fifo.sv
